>>> hdl/bgd_pkg.sv
// ---------------------------------------------------------------------------
// bgd_pkg
// shared types and constants of the button gesture detector
// ---------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

    localparam int TICK_WIDTH_DEF = 32;
    localparam int NOW_W          = 32;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int EVENT_W        = 3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] CLICK_RST    = 16'd300;
    localparam logic [CFG_W-1:0] RELEASE_RST  = 16'd300;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_CLICK    = 3'd1,
        REG_RELEASE  = 3'd2,
        REG_HOLD     = 3'd3
    } t_reg_idx;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 3'd0,
        EV_SINGLE  = 3'd1,
        EV_DOUBLE  = 3'd2,
        EV_HOLD    = 3'd3,
        EV_RELEASE = 3'd4,
        EV_ERROR   = 3'd5
    } t_event;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_POSEDGE    = 4'd1,
        ST_FIRST      = 4'd2,
        ST_END_FIRST  = 4'd3,
        ST_SINGLE     = 4'd4,
        ST_PRE_SECOND = 4'd5,
        ST_SECOND     = 4'd6,
        ST_DOUBLE     = 4'd7,
        ST_WAIT_HOLD  = 4'd8,
        ST_HOLD       = 4'd9,
        ST_WAIT_REL   = 4'd10,
        ST_RELEASE    = 4'd11,
        ST_ERROR      = 4'd12
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] click_ticks;
        logic [CFG_W-1:0] release_ticks;
        logic [CFG_W-1:0] hold_ticks;
    } t_cfg;

endpackage

`default_nettype wire

>>> hdl/bgd_in_if.sv
// ---------------------------------------------------------------------------
// bgd_in_if
// poll channel: button level and tick counter
// ---------------------------------------------------------------------------
`default_nettype none

interface bgd_in_if;
    logic        valid;
    logic        ready;
    logic        pressed;
    logic [31:0] now_tick;

    modport source (output valid, output pressed, output now_tick, input ready);
    modport sink   (input valid, input pressed, input now_tick, output ready);
endinterface

`default_nettype wire

>>> hdl/bgd_out_if.sv
// ---------------------------------------------------------------------------
// bgd_out_if
// event channel: one event code per poll
// ---------------------------------------------------------------------------
`default_nettype none

interface bgd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

`default_nettype wire

>>> hdl/bgd_in_stage.sv
// ---------------------------------------------------------------------------
// bgd_in_stage
// input register for one poll word
// ---------------------------------------------------------------------------
`default_nettype none

module bgd_in_stage
    import bgd_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bgd_in_if.sink                     i_in,
    input  wire logic                  i_adv,
    output logic                       o_valid,
    output logic                       o_pressed,
    output logic [TICK_WIDTH-1:0]      o_now
);

    logic                  r_valid;
    logic                  r_pressed;
    logic [TICK_WIDTH-1:0] r_now;
    logic                  w_take;

    assign i_in.ready = !r_valid || i_adv;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    // only the low tick bits count, wider counters see zeros on top
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pressed <= i_in.pressed;
            r_now     <= TICK_WIDTH'(i_in.now_tick);
        end
    end

    assign o_valid   = r_valid;
    assign o_pressed = r_pressed;
    assign o_now     = r_now;

endmodule

`default_nettype wire

>>> hdl/bgd_fsm.sv
// ---------------------------------------------------------------------------
// bgd_fsm
// gesture state machine, start time and event register
// ---------------------------------------------------------------------------
`default_nettype none

module bgd_fsm
    import bgd_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_valid,
    input  wire logic                  i_pressed,
    input  wire logic [TICK_WIDTH-1:0] i_now,
    output logic                       o_adv,
    bgd_out_if.source                  o_out
);

    t_state                r_state, n_state;
    t_event                r_event, n_event;
    logic [TICK_WIDTH-1:0] r_start;
    logic                  n_load;
    logic                  r_out_valid;
    logic                  w_fire;

    logic [TICK_WIDTH-1:0] w_el;
    logic                  w_ge_deb, w_ge_click, w_ge_rel, w_gt_rel, w_gt_hold;

    assign o_adv  = !r_out_valid || o_out.ready;
    assign w_fire = i_valid && o_adv;

    // elapsed time wraps with the tick counter
    assign w_el       = i_now - r_start;
    assign w_ge_deb   = w_el >= TICK_WIDTH'(i_cfg.debounce_ticks);
    assign w_ge_click = w_el >= TICK_WIDTH'(i_cfg.click_ticks);
    assign w_ge_rel   = w_el >= TICK_WIDTH'(i_cfg.release_ticks);
    assign w_gt_rel   = w_el >  TICK_WIDTH'(i_cfg.release_ticks);
    assign w_gt_hold  = w_el >  TICK_WIDTH'(i_cfg.hold_ticks);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_pressed) n_state = ST_POSEDGE;
            end
            ST_POSEDGE: begin
                if (w_ge_deb) n_state = i_pressed ? ST_FIRST : ST_IDLE;
            end
            ST_FIRST: begin
                if (!i_pressed && !w_ge_click) n_state = ST_END_FIRST;
                else if (w_ge_click)           n_state = ST_WAIT_HOLD;
            end
            ST_END_FIRST: begin
                if (!i_pressed && w_ge_rel)      n_state = ST_SINGLE;
                else if (i_pressed && !w_ge_rel) n_state = ST_PRE_SECOND;
            end
            ST_SINGLE:  n_state = ST_IDLE;
            ST_PRE_SECOND: begin
                if (w_ge_deb) n_state = i_pressed ? ST_SECOND : ST_SINGLE;
            end
            ST_SECOND: begin
                if (!i_pressed && !w_ge_click)     n_state = ST_DOUBLE;
                else if (i_pressed && w_ge_click)  n_state = ST_ERROR;
            end
            ST_DOUBLE:  n_state = ST_IDLE;
            ST_WAIT_HOLD: begin
                if (!i_pressed && !w_gt_hold) n_state = ST_ERROR;
                else if (w_gt_hold)           n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (!i_pressed) n_state = ST_WAIT_REL;
            end
            ST_WAIT_REL: begin
                if (i_pressed && !w_gt_rel) n_state = ST_HOLD;
                else if (w_gt_rel)          n_state = ST_RELEASE;
            end
            ST_RELEASE: n_state = ST_IDLE;
            ST_ERROR:   n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_event = r_event;
        n_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_event = EV_NONE;
                n_load  = i_pressed;
            end
            ST_POSEDGE:    n_load = w_ge_deb && i_pressed;
            ST_FIRST:      n_load = !i_pressed && !w_ge_click;
            ST_END_FIRST:  n_load = i_pressed && !w_ge_rel;
            ST_SINGLE:     n_event = EV_SINGLE;
            ST_PRE_SECOND: n_load = w_ge_deb && i_pressed;
            ST_DOUBLE:     n_event = EV_DOUBLE;
            ST_HOLD: begin
                n_event = EV_HOLD;
                n_load  = !i_pressed;
            end
            ST_RELEASE:    n_event = EV_RELEASE;
            ST_ERROR:      n_event = EV_ERROR;
            default: begin
                n_event = r_event;
                n_load  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_event     <= EV_NONE;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_state <= n_state;
                r_event <= n_event;
                if (n_load) r_start <= i_now;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_code = r_event;

endmodule

`default_nettype wire

>>> hdl/button_gesture_detector.sv
// ---------------------------------------------------------------------------
// button_gesture_detector
// push-button click, double click, hold and release detector
// ---------------------------------------------------------------------------
// Each poll word carries the button level and a millisecond tick; each poll
// gives exactly one word back, the event register after that poll. One poll
// is taken every clock cycle unless the input is held off; a poll goes through
// the input register and the state machine into the event register, and the
// input is held off only while both registers are full and the output is
// stalled. Elapsed time is the wrapping difference of the low TICK_WIDTH tick
// bits. Timing windows are to be written through the config port only while
// idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module button_gesture_detector
    import bgd_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bgd_in_if.sink                    i_in,
    bgd_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  w_adv;
    logic                  w_valid;
    logic                  w_pressed;
    logic [TICK_WIDTH-1:0] w_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.click_ticks    <= CLICK_RST;
            r_cfg.release_ticks  <= RELEASE_RST;
            r_cfg.hold_ticks     <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEBOUNCE: r_cfg.debounce_ticks <= i_cfg_data;
                REG_CLICK:    r_cfg.click_ticks    <= i_cfg_data;
                REG_RELEASE:  r_cfg.release_ticks  <= i_cfg_data;
                REG_HOLD:     r_cfg.hold_ticks     <= i_cfg_data;
                default:      r_cfg                <= r_cfg;
            endcase
        end
    end

    bgd_in_stage #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_adv     (w_adv),
        .o_valid   (w_valid),
        .o_pressed (w_pressed),
        .o_now     (w_now)
    );

    bgd_fsm #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (w_valid),
        .i_pressed (w_pressed),
        .i_now     (w_now),
        .o_adv     (w_adv),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

>>> hdl/bgd_checker.sv
// ---------------------------------------------------------------------------
// bgd_checker
// port-level checks of the gesture detector
// ---------------------------------------------------------------------------
`default_nettype none

module bgd_checker
    import bgd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [EVENT_W-1:0] i_event_code
);

    // no word may come out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word after reset");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_code <= EV_ERROR))
        else $error("event code out of range");

    // input side only backs up when the output side is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled while output free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_event_code)))
        else $error("stalled output word changed");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_event_code (o_out.event_code)
);

`default_nettype wire
